### design/fipa_pkg.sv
// Shared types and constants for the free index pool allocator.
// No dependencies; used by fipa_free_stack and free_index_pool_allocator.
package fipa_pkg;

    localparam int POOL_DEPTH     = 1024;
    localparam int IDX_W          = $clog2(POOL_DEPTH);
    localparam int COUNT_W        = IDX_W + 1;
    localparam int ENTRIES_W      = 11;
    localparam int SLOT_W         = 13;
    localparam int OFFSET_W       = 22;
    localparam int CFG_IDX_W      = 2;
    localparam int MAX_SLOT_BYTES = 4096;

    typedef enum logic [1:0] {
        OP_OBTAIN   = 2'd0,
        OP_RELEASE  = 2'd1,
        OP_FREE_ALL = 2'd2,
        OP_ACCESS   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_ENTRIES = 2'd0,
        CFG_SLOT_BYTES   = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
        logic             clear;
    } stack_req_t;

endpackage

### design/free_index_pool_allocator.sv
// Free index pool allocator: an accept in S_IDLE issues the stack memory read,
// then S_EXEC writes back and registers the result once the output is free.
// A pending result in the output register does not block the next accept.
// Reset: pool_entries 1024, slot_bytes 64, stack head 0; the stack memory is
// not swept, a watermark makes every entry read as its own index at once.
// Free-all takes the same steps. Depends on fipa_pkg and fipa_free_stack.
module free_index_pool_allocator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_operation,
    input  logic [9:0]                       s_slot_index,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [9:0]                       m_granted_index,
    output logic [21:0]                      m_byte_offset,
    output logic [1:0]                       m_status,
    output logic [10:0]                      m_in_use_count,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fipa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [12:0]                      cfg_data
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    fipa_pkg::op_t                  op_reg;
    logic [fipa_pkg::IDX_W-1:0]     idx_reg;
    logic [fipa_pkg::COUNT_W-1:0]   head_reg;
    logic [fipa_pkg::COUNT_W-1:0]   head_next;
    logic [fipa_pkg::ENTRIES_W-1:0] pool_entries_reg;
    logic [fipa_pkg::SLOT_W-1:0]    slot_bytes_reg;

    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [fipa_pkg::IDX_W-1:0]     granted_reg;
    logic [fipa_pkg::IDX_W-1:0]     granted_next;
    logic [fipa_pkg::OFFSET_W-1:0]  offset_reg;
    logic [fipa_pkg::OFFSET_W-1:0]  offset_next;
    fipa_pkg::status_t              status_reg;
    fipa_pkg::status_t              status_next;

    fipa_pkg::stack_req_t           stack_req;
    logic [fipa_pkg::IDX_W-1:0]     stack_rd_data;

    logic                           in_fire;
    logic                           out_free;
    logic                           exec_fire;
    logic [fipa_pkg::COUNT_W-1:0]   pool_size;
    logic [fipa_pkg::SLOT_W-1:0]    slot_size;
    logic [fipa_pkg::COUNT_W-1:0]   idx_ext;
    logic [fipa_pkg::OFFSET_W:0]    product;

    fipa_free_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (stack_req),
        .rd_data (stack_rd_data)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign exec_fire = (state_reg == S_EXEC) && out_free;
    assign cfg_ready = 1'b1;

    assign pool_size = (pool_entries_reg > fipa_pkg::ENTRIES_W'(fipa_pkg::POOL_DEPTH))
                     ? fipa_pkg::COUNT_W'(fipa_pkg::POOL_DEPTH)
                     : fipa_pkg::COUNT_W'(pool_entries_reg);
    assign slot_size = (slot_bytes_reg > fipa_pkg::SLOT_W'(fipa_pkg::MAX_SLOT_BYTES))
                     ? fipa_pkg::SLOT_W'(fipa_pkg::MAX_SLOT_BYTES)
                     : slot_bytes_reg;
    assign idx_ext   = {1'b0, idx_reg};
    assign product   = {{(fipa_pkg::OFFSET_W + 1 - fipa_pkg::IDX_W){1'b0}}, idx_reg}
                     * {{(fipa_pkg::OFFSET_W + 1 - fipa_pkg::SLOT_W){1'b0}}, slot_size};

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        m_valid_next = m_valid_reg && !m_ready;
        granted_next = granted_reg;
        offset_next  = offset_reg;
        status_next  = status_reg;

        stack_req         = '0;
        stack_req.rd_en   = in_fire;
        stack_req.rd_addr = head_reg[fipa_pkg::IDX_W-1:0];

        if (in_fire) begin
            state_next = S_EXEC;
        end

        if (exec_fire) begin
            state_next   = S_IDLE;
            m_valid_next = 1'b1;
            granted_next = '0;
            offset_next  = '0;
            status_next  = fipa_pkg::ST_OK;
            case (op_reg)
                fipa_pkg::OP_OBTAIN: begin
                    if (head_reg < pool_size) begin
                        granted_next      = stack_rd_data;
                        stack_req.wr_en   = 1'b1;
                        stack_req.wr_addr = head_reg[fipa_pkg::IDX_W-1:0];
                        stack_req.wr_data = stack_rd_data;
                        head_next         = head_reg + fipa_pkg::COUNT_W'(1);
                    end else begin
                        status_next = fipa_pkg::ST_EXHAUSTED;
                    end
                end
                fipa_pkg::OP_RELEASE: begin
                    if (head_reg == '0) begin
                        status_next = fipa_pkg::ST_EMPTY;
                    end else if (idx_ext >= pool_size) begin
                        status_next = fipa_pkg::ST_RANGE;
                    end else begin
                        head_next         = head_reg - fipa_pkg::COUNT_W'(1);
                        stack_req.wr_en   = 1'b1;
                        stack_req.wr_addr = head_next[fipa_pkg::IDX_W-1:0];
                        stack_req.wr_data = idx_reg;
                    end
                end
                fipa_pkg::OP_FREE_ALL: begin
                    stack_req.clear = 1'b1;
                    head_next       = '0;
                end
                fipa_pkg::OP_ACCESS: begin
                    if (idx_ext >= pool_size) begin
                        status_next = fipa_pkg::ST_RANGE;
                    end else begin
                        offset_next = product[fipa_pkg::OFFSET_W-1:0];
                    end
                end
                default: begin
                    status_next = fipa_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            head_reg         <= '0;
            m_valid_reg      <= 1'b0;
            pool_entries_reg <= fipa_pkg::ENTRIES_W'(1024);
            slot_bytes_reg   <= fipa_pkg::SLOT_W'(64);
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    fipa_pkg::CFG_POOL_ENTRIES: begin
                        pool_entries_reg <= cfg_data[fipa_pkg::ENTRIES_W-1:0];
                    end
                    fipa_pkg::CFG_SLOT_BYTES: begin
                        slot_bytes_reg <= cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg  <= fipa_pkg::op_t'(s_operation);
            idx_reg <= s_slot_index;
        end
        granted_reg <= granted_next;
        offset_reg  <= offset_next;
        status_reg  <= status_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_granted_index = granted_reg;
    assign m_byte_offset   = offset_reg;
    assign m_status        = status_reg;
    assign m_in_use_count  = head_reg;

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= fipa_pkg::COUNT_W'(fipa_pkg::POOL_DEPTH))
        else $error("stack head beyond pool depth");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == S_EXEC))
        else $error("accepted beat not executed");

    a_exhausted_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != fipa_pkg::ST_OK)) |-> (m_granted_index == '0)
            && (m_byte_offset == '0))
        else $error("failed operation returned payload");

endmodule

### design/fipa_free_stack.sv
// Free-index stack memory with a write watermark: entries at or above the
// watermark read as their own index, so refill only clears the watermark.
// Depends on fipa_pkg.
module fipa_free_stack (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fipa_pkg::stack_req_t       req,
    output logic [fipa_pkg::IDX_W-1:0] rd_data
);

    logic [fipa_pkg::IDX_W-1:0]   mem [fipa_pkg::POOL_DEPTH];
    logic [fipa_pkg::IDX_W-1:0]   mem_q_reg;
    logic [fipa_pkg::IDX_W-1:0]   addr_q_reg;
    logic                         stored_reg;
    logic [fipa_pkg::COUNT_W-1:0] hw_reg;
    logic [fipa_pkg::COUNT_W-1:0] hw_next;
    logic [fipa_pkg::COUNT_W-1:0] wr_addr_ext;
    logic [fipa_pkg::COUNT_W-1:0] rd_addr_ext;

    assign wr_addr_ext = {1'b0, req.wr_addr};
    assign rd_addr_ext = {1'b0, req.rd_addr};

    always_comb begin
        hw_next = hw_reg;
        if (req.clear) begin
            hw_next = '0;
        end else if (req.wr_en && (wr_addr_ext >= hw_reg)) begin
            hw_next = wr_addr_ext + fipa_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            mem_q_reg  <= mem[req.rd_addr];
            addr_q_reg <= req.rd_addr;
            stored_reg <= (rd_addr_ext < hw_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hw_reg <= '0;
        end else begin
            hw_reg <= hw_next;
        end
    end

    assign rd_data = stored_reg ? mem_q_reg : addr_q_reg;

    a_hw_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hw_reg <= fipa_pkg::COUNT_W'(fipa_pkg::POOL_DEPTH))
        else $error("watermark beyond pool depth");

    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        req.wr_en |-> (wr_addr_ext <= hw_reg))
        else $error("write leaves unwritten gap below watermark");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        req.clear |=> (hw_reg == '0))
        else $error("clear did not reset watermark");

endmodule

### dv/free_index_pool_allocator_tb.sv
// Testbench for free_index_pool_allocator: a queue-fed driver, a result monitor and a
// built-in predictor of the free-index stack. The register settings change between phases.
// Depends on fipa_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module free_index_pool_allocator_tb;

    localparam logic [fipa_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [fipa_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct {
        fipa_pkg::op_t op;
        logic [9:0]    idx;
    } pool_req_t;

    typedef struct {
        logic [9:0]        granted;
        logic [21:0]       offset;
        fipa_pkg::status_t status;
        logic [10:0]       count;
    } alloc_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = '0;
    logic [9:0]  s_slot_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [9:0]  m_granted_index;
    logic [21:0] m_byte_offset;
    logic [1:0]  m_status;
    logic [10:0] m_in_use_count;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [fipa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [12:0] cfg_data = '0;

    pool_req_t     op_backlog[$];
    alloc_result_t due_results[$];
    logic [9:0]    free_list[fipa_pkg::POOL_DEPTH];
    int            list_head;
    logic [10:0]   pool_entries_q;
    logic [12:0]   slot_bytes_q;
    int            errors = 0;
    int            cycle_count = 0;
    logic          quiet;

    free_index_pool_allocator DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_slot_index    (s_slot_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted_index (m_granted_index),
        .m_byte_offset   (m_byte_offset),
        .m_status        (m_status),
        .m_in_use_count  (m_in_use_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // periodic stretch with no idling on either side
    assign quiet = (cycle_count % 6000) >= 1500 && (cycle_count % 6000) < 2500;

    function automatic int eff_pool();
        return (pool_entries_q > fipa_pkg::POOL_DEPTH) ? fipa_pkg::POOL_DEPTH
                                                       : int'(pool_entries_q);
    endfunction

    function automatic void reset_pool_state();
        for (int i = 0; i < fipa_pkg::POOL_DEPTH; i++) free_list[i] = i[9:0];
        list_head = 0;
    endfunction

    function automatic void predict_outcome(fipa_pkg::op_t op, logic [9:0] idx);
        alloc_result_t r;
        int size;
        int slot;
        size = eff_pool();
        slot = (slot_bytes_q > fipa_pkg::MAX_SLOT_BYTES) ? fipa_pkg::MAX_SLOT_BYTES
                                                          : int'(slot_bytes_q);
        r.granted = '0;
        r.offset  = '0;
        r.status  = fipa_pkg::ST_OK;
        case (op)
            fipa_pkg::OP_OBTAIN: begin
                if (list_head < size) begin
                    r.granted = free_list[list_head];
                    list_head++;
                end else begin
                    r.status = fipa_pkg::ST_EXHAUSTED;
                end
            end
            fipa_pkg::OP_RELEASE: begin
                if (list_head == 0) begin
                    r.status = fipa_pkg::ST_EMPTY;
                end else if (int'(idx) >= size) begin
                    r.status = fipa_pkg::ST_RANGE;
                end else begin
                    list_head--;
                    free_list[list_head] = idx;
                end
            end
            fipa_pkg::OP_FREE_ALL: begin
                reset_pool_state();
            end
            default: begin
                if (int'(idx) >= size) r.status = fipa_pkg::ST_RANGE;
                else r.offset = 22'(int'(idx) * slot);
            end
        endcase
        r.count = 11'(list_head);
        due_results.push_back(r);
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // driver: one request beat at a time from the backlog
    always @(posedge aclk) begin : drive_requests
        pool_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_outcome(fipa_pkg::op_t'(s_operation), s_slot_index);
            end
            if (!s_valid || s_ready) begin
                if (op_backlog.size() > 0 && (quiet || $urandom_range(99) >= 24)) begin
                    nxt = op_backlog.pop_front();
                    s_valid      <= 1'b1;
                    s_operation  <= nxt.op;
                    s_slot_index <= nxt.idx;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result beat against the oldest prediction
    always @(posedge aclk) begin : check_results
        alloc_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result beat, status %0d count %0d",
                             $time, m_status, m_in_use_count);
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    check_field("granted_index", int'(want.granted), int'(m_granted_index));
                    check_field("byte_offset", int'(want.offset), int'(m_byte_offset));
                    check_field("status", int'(want.status), int'(m_status));
                    check_field("in_use_count", int'(want.count), int'(m_in_use_count));
                end
            end
            m_ready <= quiet || $urandom_range(99) >= 24;
        end
    end

    task automatic push_req(fipa_pkg::op_t op, logic [9:0] idx);
        pool_req_t r;
        r.op  = op;
        r.idx = idx;
        op_backlog.push_back(r);
    endtask

    task automatic write_reg(logic [fipa_pkg::CFG_IDX_W-1:0] idx, logic [12:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            fipa_pkg::CFG_POOL_ENTRIES: pool_entries_q = data[10:0];
            fipa_pkg::CFG_SLOT_BYTES:   slot_bytes_q = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // sampled away from the active edge so queue and valid updates have settled
    task automatic wait_idle();
        @(negedge aclk);
        while (op_backlog.size() > 0 || s_valid || due_results.size() > 0) @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [9:0] pick_index();
        int size;
        size = eff_pool();
        if (size > 0 && $urandom_range(99) < 85) return 10'($urandom_range(size - 1, 0));
        return 10'($urandom_range(1023, 0));
    endfunction

    task automatic run_phase(int n, int w_obtain, int w_release, int w_free);
        int roll;
        fipa_pkg::op_t op;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            if (roll < w_obtain) op = fipa_pkg::OP_OBTAIN;
            else if (roll < w_obtain + w_release) op = fipa_pkg::OP_RELEASE;
            else if (roll < w_obtain + w_release + w_free) op = fipa_pkg::OP_FREE_ALL;
            else op = fipa_pkg::OP_ACCESS;
            push_req(op, pick_index());
        end
        wait_idle();
    endtask

    initial begin
        pool_entries_q = 11'd1024;
        slot_bytes_q   = 13'd64;
        reset_pool_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: empty release, offset extremes, stack push and pop
        push_req(fipa_pkg::OP_RELEASE, 10'd1023);
        push_req(fipa_pkg::OP_ACCESS, 10'd0);
        push_req(fipa_pkg::OP_ACCESS, 10'd1023);
        repeat (3) push_req(fipa_pkg::OP_OBTAIN, 10'd0);
        push_req(fipa_pkg::OP_RELEASE, 10'd1023);
        push_req(fipa_pkg::OP_OBTAIN, 10'd0);
        push_req(fipa_pkg::OP_FREE_ALL, 10'h2AA);
        push_req(fipa_pkg::OP_OBTAIN, 10'h3FF);
        wait_idle();

        // tiny pool, upper data bits dropped; largest slot size
        write_reg(fipa_pkg::CFG_POOL_ENTRIES, 13'h1803);
        write_reg(fipa_pkg::CFG_SLOT_BYTES, 13'd4096);
        repeat (3) push_req(fipa_pkg::OP_OBTAIN, 10'd0);
        push_req(fipa_pkg::OP_ACCESS, 10'd2);
        push_req(fipa_pkg::OP_ACCESS, 10'd3);
        push_req(fipa_pkg::OP_RELEASE, 10'd3);
        push_req(fipa_pkg::OP_RELEASE, 10'd0);
        wait_idle();

        // empty pool, slot size clamped
        write_reg(fipa_pkg::CFG_POOL_ENTRIES, 13'd0);
        write_reg(fipa_pkg::CFG_SLOT_BYTES, 13'h1FFF);
        push_req(fipa_pkg::OP_OBTAIN, 10'd0);
        push_req(fipa_pkg::OP_ACCESS, 10'd0);
        push_req(fipa_pkg::OP_RELEASE, 10'd0);
        push_req(fipa_pkg::OP_FREE_ALL, 10'h155);
        push_req(fipa_pkg::OP_RELEASE, 10'd0);
        wait_idle();

        // zero slot size, pool clamped to depth, unused register indexes
        write_reg(fipa_pkg::CFG_SLOT_BYTES, 13'd0);
        write_reg(fipa_pkg::CFG_POOL_ENTRIES, 13'd2047);
        write_reg(CFG_SPARE_LO, 13'h1555);
        write_reg(CFG_SPARE_HI, 13'h0AAA);
        push_req(fipa_pkg::OP_ACCESS, 10'd1023);
        wait_idle();

        // fill the whole pool and run into exhaustion
        write_reg(fipa_pkg::CFG_POOL_ENTRIES, 13'd1024);
        write_reg(fipa_pkg::CFG_SLOT_BYTES, 13'd4096);
        run_phase(1100, 97, 1, 0);

        // shrink under a full pool, then drain it back
        write_reg(fipa_pkg::CFG_POOL_ENTRIES, 13'd2);
        write_reg(fipa_pkg::CFG_SLOT_BYTES, 13'd1);
        run_phase(60, 30, 50, 2);

        write_reg(fipa_pkg::CFG_POOL_ENTRIES, 13'd1);
        write_reg(fipa_pkg::CFG_SLOT_BYTES, 13'h1000);
        run_phase(60, 40, 40, 5);

        write_reg(fipa_pkg::CFG_POOL_ENTRIES, 13'd37);
        write_reg(fipa_pkg::CFG_SLOT_BYTES, 13'($urandom_range(8191, 0)));
        run_phase(150, 45, 40, 3);

        write_reg(fipa_pkg::CFG_POOL_ENTRIES, 13'($urandom_range(8191, 0)));
        write_reg(fipa_pkg::CFG_SLOT_BYTES, 13'($urandom_range(8191, 0)));
        run_phase(150, 45, 40, 3);

        write_reg(fipa_pkg::CFG_POOL_ENTRIES, 13'd0);
        write_reg(fipa_pkg::CFG_SLOT_BYTES, 13'd64);
        run_phase(30, 40, 30, 5);

        write_reg(fipa_pkg::CFG_POOL_ENTRIES, 13'd1024);
        write_reg(fipa_pkg::CFG_SLOT_BYTES, 13'd1);
        run_phase(150, 50, 40, 2);

        repeat (10) @(posedge aclk);
        if (errors == 0 && due_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
